FILE: design/ptw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the x86 page table walker.
package ptw_pkg;

    localparam int ADDR_W = 52;
    localparam int VA_W   = 48;
    localparam int LVL_W  = 3;

    typedef enum logic [1:0] {
        MODE_CLASSIC = 2'd0,
        MODE_PAE     = 2'd1,
        MODE_LONG    = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_ROOT = 1'b1;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] entry_address;
        logic              entry_wide;
        logic              mapped;
        logic              large_page;
        logic [ADDR_W-1:0] translated_address;
    } t_result;

    typedef struct packed {
        logic             emit;
        logic             busy;
        logic [LVL_W-1:0] level;
        t_result          res;
    } t_step;

endpackage

FILE: design/ptw_in_if.sv
`timescale 1ns / 1ps
// Input channel: translate requests and memory read responses.
interface ptw_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] virtual_address;
    logic [63:0] entry_data;

    modport source (output valid, output opcode, output virtual_address,
                    output entry_data, input ready);
    modport sink   (input valid, input opcode, input virtual_address,
                    input entry_data, output ready);
endinterface

FILE: design/ptw_out_if.sv
`timescale 1ns / 1ps
// Output channel: entry read requests and walk results.
interface ptw_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [51:0] entry_address;
    logic        entry_wide;
    logic        mapped;
    logic        large_page;
    logic [51:0] translated_address;

    modport source (output valid, output result_kind, output entry_address,
                    output entry_wide, output mapped, output large_page,
                    output translated_address, input ready);
    modport sink   (input valid, input result_kind, input entry_address,
                    input entry_wide, input mapped, input large_page,
                    input translated_address, output ready);
endinterface

FILE: design/ptw_step.sv
`timescale 1ns / 1ps
// One walk step: next read address or final translation from the current item and walk state.
module ptw_step #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  ptw_pkg::t_mode                 i_mode,
    input  logic [ptw_pkg::ADDR_W-1:0]     i_root,
    input  logic                           i_busy,
    input  logic [ptw_pkg::LVL_W-1:0]      i_level,
    input  logic [ptw_pkg::VA_W-1:0]       i_held_va,
    input  logic                           i_opcode,
    input  logic [63:0]                    i_va,
    input  logic [63:0]                    i_entry,
    output ptw_pkg::t_step                 o_step
);

    localparam logic [ptw_pkg::ADDR_W-1:0] PhysMask =
        {ptw_pkg::ADDR_W{1'b1}} >> (ptw_pkg::ADDR_W - PHYS_ADDR_BITS);
    localparam logic [ptw_pkg::ADDR_W-1:0] PageMask = ~ptw_pkg::ADDR_W'(12'hfff);
    localparam logic [ptw_pkg::ADDR_W-1:0] LargeMask = ~ptw_pkg::ADDR_W'(21'h1fffff);
    localparam logic [ptw_pkg::ADDR_W-1:0] RootMask = ~ptw_pkg::ADDR_W'(5'h1f);

    function automatic ptw_pkg::t_result f_read(logic [ptw_pkg::ADDR_W-1:0] a, logic w);
        ptw_pkg::t_result r;
        r               = '0;
        r.kind          = ptw_pkg::KIND_READ;
        r.entry_address = a;
        r.entry_wide    = w;
        return r;
    endfunction

    function automatic ptw_pkg::t_result f_done(logic lg, logic [ptw_pkg::ADDR_W-1:0] pa);
        ptw_pkg::t_result r;
        r                    = '0;
        r.kind               = ptw_pkg::KIND_DONE;
        r.mapped             = 1'b1;
        r.large_page         = lg;
        r.translated_address = pa;
        return r;
    endfunction

    function automatic ptw_pkg::t_result f_fault();
        ptw_pkg::t_result r;
        r      = '0;
        r.kind = ptw_pkg::KIND_DONE;
        return r;
    endfunction

    logic [31:0]                 root32;
    logic [31:0]                 a_cl0;
    logic [31:0]                 a_pae0;
    logic [ptw_pkg::ADDR_W-1:0]  a_long0;
    logic [31:0]                 e32;
    logic [31:0]                 a_cl1;
    logic [ptw_pkg::ADDR_W-1:0]  frame;
    logic [ptw_pkg::LVL_W-1:0]   nxt_lvl;
    logic [ptw_pkg::LVL_W-1:0]   last_lvl;
    logic [8:0]                  idx;
    logic [ptw_pkg::ADDR_W-1:0]  a_wide;
    logic                        present;

    assign root32  = {i_root[31:5], 5'b0};
    assign a_cl0   = root32 + {20'b0, i_va[31:22], 2'b0};
    assign a_pae0  = root32 + {27'b0, i_va[31:30], 3'b0};
    assign a_long0 = ((i_root & PhysMask & RootMask) + {40'b0, i_va[47:39], 3'b0}) & PhysMask;

    assign e32     = i_entry[31:0];
    assign a_cl1   = {e32[31:12], 12'b0} + {20'b0, i_held_va[21:12], 2'b0};
    assign frame   = i_entry[ptw_pkg::ADDR_W-1:0] & PhysMask & PageMask;
    assign nxt_lvl = i_level + ptw_pkg::LVL_W'(1);
    assign last_lvl = (i_mode == ptw_pkg::MODE_PAE) ? ptw_pkg::LVL_W'(2) : ptw_pkg::LVL_W'(3);
    assign a_wide  = frame + {40'b0, idx, 3'b0};

    always_comb begin
        if (i_mode == ptw_pkg::MODE_PAE) begin
            idx = (nxt_lvl == ptw_pkg::LVL_W'(1)) ? i_held_va[29:21] : i_held_va[20:12];
        end else begin
            case (nxt_lvl)
                ptw_pkg::LVL_W'(1): idx = i_held_va[38:30];
                ptw_pkg::LVL_W'(2): idx = i_held_va[29:21];
                default:            idx = i_held_va[20:12];
            endcase
        end
    end

    always_comb begin
        present      = i_entry[ptw_pkg::BIT_PRESENT];
        o_step       = '0;
        o_step.busy  = i_busy;
        o_step.level = i_level;
        o_step.res   = f_fault();
        if (i_opcode == ptw_pkg::OP_TRANSLATE) begin
            o_step.emit  = 1'b1;
            o_step.busy  = 1'b1;
            o_step.level = '0;
            case (i_mode)
                ptw_pkg::MODE_CLASSIC: o_step.res = f_read({20'b0, a_cl0}, 1'b0);
                ptw_pkg::MODE_PAE:     o_step.res = f_read({20'b0, a_pae0}, 1'b1);
                ptw_pkg::MODE_LONG:    o_step.res = f_read(a_long0, 1'b1);
                default: begin
                    o_step.busy = 1'b0;
                end
            endcase
        end else if (i_busy) begin
            o_step.emit  = 1'b1;
            o_step.busy  = 1'b0;
            o_step.level = '0;
            case (i_mode)
                ptw_pkg::MODE_CLASSIC: begin
                    if (i_level <= ptw_pkg::LVL_W'(1) && present) begin
                        if (i_level == '0) begin
                            if (e32[ptw_pkg::BIT_LARGE]) begin
                                o_step.res = f_done(1'b1,
                                    {20'b0, e32[31:22], i_held_va[21:0]});
                            end else begin
                                o_step.busy  = 1'b1;
                                o_step.level = ptw_pkg::LVL_W'(1);
                                o_step.res   = f_read({20'b0, a_cl1}, 1'b0);
                            end
                        end else begin
                            o_step.res = f_done(1'b0, {20'b0, e32[31:12], i_held_va[11:0]});
                        end
                    end
                end
                ptw_pkg::MODE_PAE, ptw_pkg::MODE_LONG: begin
                    if (i_level <= last_lvl && present) begin
                        if (i_mode == ptw_pkg::MODE_PAE && i_level == ptw_pkg::LVL_W'(1)
                                && i_entry[ptw_pkg::BIT_LARGE]) begin
                            o_step.res = f_done(1'b1, (frame & LargeMask)
                                | {31'b0, i_held_va[20:0]});
                        end else if (i_level == last_lvl) begin
                            o_step.res = f_done(1'b0, frame | {40'b0, i_held_va[11:0]});
                        end else begin
                            o_step.busy  = 1'b1;
                            o_step.level = nxt_lvl;
                            o_step.res   = f_read(a_wide, 1'b1);
                        end
                    end
                end
                default: begin
                    o_step.res = f_fault();
                end
            endcase
        end
    end

endmodule

FILE: design/x86_page_table_walker.sv
`timescale 1ns / 1ps
// Top level of the x86 page table walker: walk state, config and output buffering.
//
//  channel  dir  payload                                            handshake
//  i_in     in   opcode, virtual_address, entry_data                valid/ready
//  o_out    out  result_kind, entry_address, entry_wide, mapped,    valid/ready
//                large_page, translated_address
//  i_cfg_*  in   index 0 paging_mode, index 1 table_root            write enable
//
// One item per cycle while i_in.ready is high; each result is registered.
// The walk step is a single combinational pass from walk state and item into the
// output register; a skid register behind it keeps ready independent of o_out.ready.
// Synchronous active-low reset clears busy, level, config and both valid flags.
// i_in.ready drops only while the skid register holds a result.
module x86_page_table_walker #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [ptw_pkg::ADDR_W-1:0] i_cfg_data,
    ptw_in_if.sink                     i_in,
    ptw_out_if.source                  o_out
);

    ptw_pkg::t_mode                r_mode;
    logic [ptw_pkg::ADDR_W-1:0]    r_root;
    logic                          r_busy;
    logic [ptw_pkg::LVL_W-1:0]     r_level;
    logic [ptw_pkg::VA_W-1:0]      r_held_va;
    logic                          r_out_v;
    logic                          r_skid_v;
    ptw_pkg::t_result              r_out;
    ptw_pkg::t_result              r_skid;

    ptw_pkg::t_step                step;
    logic                          in_acc;
    logic                          push;
    logic                          out_free;
    logic                          n_out_v;
    logic                          n_skid_v;

    ptw_step #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_step (
        .i_mode    (r_mode),
        .i_root    (r_root),
        .i_busy    (r_busy),
        .i_level   (r_level),
        .i_held_va (r_held_va),
        .i_opcode  (i_in.opcode),
        .i_va      (i_in.virtual_address),
        .i_entry   (i_in.entry_data),
        .o_step    (step)
    );

    assign i_in.ready = !r_skid_v;
    assign in_acc     = i_in.valid && !r_skid_v;
    assign push       = in_acc && step.emit;
    assign out_free   = !r_out_v || o_out.ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (out_free) begin
            if (r_skid_v) begin
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = push;
            end
        end else if (push) begin
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ptw_pkg::MODE_CLASSIC;
            r_root   <= '0;
            r_busy   <= 1'b0;
            r_level  <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ptw_pkg::CFG_MODE: r_mode <= ptw_pkg::t_mode'(i_cfg_data[1:0]);
                    ptw_pkg::CFG_ROOT: r_root <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_busy  <= step.busy;
                r_level <= step.level;
            end
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.opcode == ptw_pkg::OP_TRANSLATE) begin
            r_held_va <= i_in.virtual_address[ptw_pkg::VA_W-1:0];
        end
        if (out_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= step.res;
            end
        end else if (push) begin
            r_skid <= step.res;
        end
    end

    assign o_out.valid              = r_out_v;
    assign o_out.result_kind        = r_out.kind;
    assign o_out.entry_address      = r_out.entry_address;
    assign o_out.entry_wide         = r_out.entry_wide;
    assign o_out.mapped             = r_out.mapped;
    assign o_out.large_page         = r_out.large_page;
    assign o_out.translated_address = r_out.translated_address;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while output register is empty");

    a_idle_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_level == '0)
        else $error("walk level nonzero while idle");

    a_translate_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.opcode == ptw_pkg::OP_TRANSLATE && r_mode != ptw_pkg::MODE_NONE
            && !i_cfg_we)
        |=> (r_busy && r_level == '0))
        else $error("translate did not start a walk");

    a_idle_rsp_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.opcode == ptw_pkg::OP_RESPONSE && !r_busy) |-> !push)
        else $error("response while idle produced a result");

endmodule
